FILE: design/cch_pkg.sv
// ----------------------------------------------------------------------------
// cch_pkg
// shared types, codes, constants and the cordic angle table for the compass
// calibration and heading block
// ----------------------------------------------------------------------------
`default_nettype none

package cch_pkg;

  // defaults for the top level parameters
  localparam int unsigned SAMPLE_BITS_DEF  = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // fixed field widths
  localparam int unsigned OP_BITS      = 2;
  localparam int unsigned FIELD_BITS   = 16;
  localparam int unsigned STATUS_BITS  = 2;
  localparam int unsigned HEADING_BITS = 15;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // angle accumulator in 1/65536 degree
  localparam int unsigned ACC_BITS   = 26;
  localparam int unsigned ATAN_BITS  = 22;
  localparam int unsigned ATAN_IDX_BITS = 5;
  localparam logic signed [ACC_BITS-1:0] DEG180_UNITS = 26'sd11796480;
  localparam logic signed [ACC_BITS-1:0] DEG360_UNITS = 26'sd23592960;
  localparam logic signed [ACC_BITS-1:0] ROUND_HALF   = 26'sd512;
  localparam int unsigned ROUND_SHIFT = 10;
  localparam logic [ACC_BITS-ROUND_SHIFT-1:0] FULL_CIRCLE_64THS = 16'd23040;

  typedef enum logic [OP_BITS-1:0] {
    OP_START_CAL  = 2'd0,
    OP_CAL_SAMPLE = 2'd1,
    OP_HEADING    = 2'd2,
    OP_UNUSED     = 2'd3
  } cch_op_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_CAL_OK     = 2'd0,
    ST_HEAD_OK    = 2'd1,
    ST_ZERO_RANGE = 2'd2,
    ST_RESERVED   = 2'd3
  } cch_status_e;

  // atan(2^-i) in 1/65536 degree, rounded to nearest
  function automatic logic [ATAN_BITS-1:0] cch_atan(input logic [ATAN_IDX_BITS-1:0] idx);
    logic [ATAN_BITS-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: design/cch_if.sv
// ----------------------------------------------------------------------------
// cch_if
// valid/ready channels for sample requests and heading results
// ----------------------------------------------------------------------------
`default_nettype none

interface cch_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [cch_pkg::OP_BITS-1:0]           operation;
  logic signed [cch_pkg::FIELD_BITS-1:0] mag_x;
  logic signed [cch_pkg::FIELD_BITS-1:0] mag_z;

  modport source (output valid, output operation, output mag_x, output mag_z, input ready);
  modport sink   (input valid, input operation, input mag_x, input mag_z, output ready);
endinterface

interface cch_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [cch_pkg::STATUS_BITS-1:0]       status;
  logic [cch_pkg::HEADING_BITS-1:0]      heading_sixtyfourths;

  modport source (output valid, output status, output heading_sixtyfourths, input ready);
  modport sink   (input valid, input status, input heading_sixtyfourths, output ready);
endinterface

`default_nettype wire

FILE: design/cch_front.sv
// ----------------------------------------------------------------------------
// cch_front
// accepts requests, keeps the per-axis min/max and turns a heading request
// into centered offsets and ranges for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module cch_front #(
  parameter int unsigned SAMPLE_BITS = cch_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cch_in_if.sink    in_i,
  input  wire logic full_i,
  output logic      push_o,
  output logic [cch_pkg::STATUS_BITS+2*(SAMPLE_BITS+2)+2*(SAMPLE_BITS+1)-1:0] job_o
);
  localparam int unsigned DW = SAMPLE_BITS + 2;
  localparam int unsigned RW = SAMPLE_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] low_x_q, low_x_d, high_x_q, high_x_d;
  logic signed [SAMPLE_BITS-1:0] low_z_q, low_z_d, high_z_q, high_z_d;
  logic signed [SAMPLE_BITS-1:0] smp_x, smp_z;
  logic signed [DW-1:0]          dx, dz, rx_full, rz_full;
  logic [RW-1:0]                 rx, rz;
  cch_pkg::cch_status_e          status;
  cch_pkg::cch_op_e              op;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign op         = cch_pkg::cch_op_e'(in_i.operation);

  // only the low sample bits count, as a signed value
  assign smp_x = in_i.mag_x[SAMPLE_BITS-1:0];
  assign smp_z = in_i.mag_z[SAMPLE_BITS-1:0];

  assign rx_full = DW'(high_x_q) - DW'(low_x_q);
  assign rz_full = DW'(high_z_q) - DW'(low_z_q);
  assign rx      = rx_full[RW-1:0];
  assign rz      = rz_full[RW-1:0];
  assign dx      = (DW'(smp_x) <<< 1) - (DW'(low_x_q) + DW'(high_x_q));
  assign dz      = (DW'(smp_z) <<< 1) - (DW'(low_z_q) + DW'(high_z_q));

  always_comb begin
    low_x_d  = low_x_q;
    high_x_d = high_x_q;
    low_z_d  = low_z_q;
    high_z_d = high_z_q;
    status   = cch_pkg::ST_CAL_OK;
    case (op)
      cch_pkg::OP_START_CAL: begin
        low_x_d  = smp_x;
        high_x_d = smp_x;
        low_z_d  = smp_z;
        high_z_d = smp_z;
      end
      cch_pkg::OP_CAL_SAMPLE: begin
        if (smp_x > high_x_q) high_x_d = smp_x;
        if (smp_x < low_x_q)  low_x_d  = smp_x;
        if (smp_z > high_z_q) high_z_d = smp_z;
        if (smp_z < low_z_q)  low_z_d  = smp_z;
      end
      cch_pkg::OP_HEADING: begin
        if (rx == '0 || rz == '0) status = cch_pkg::ST_ZERO_RANGE;
        else                      status = cch_pkg::ST_HEAD_OK;
      end
      default: status = cch_pkg::ST_CAL_OK;
    endcase
  end

  assign job_o = {status, dx, dz, rx, rz};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_x_q  <= '0;
      high_x_q <= '0;
      low_z_q  <= '0;
      high_z_q <= '0;
    end else if (push_o) begin
      low_x_q  <= low_x_d;
      high_x_q <= high_x_d;
      low_z_q  <= low_z_d;
      high_z_q <= high_z_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/cch_queue.sv
// ----------------------------------------------------------------------------
// cch_queue
// short fifo of classified jobs between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module cch_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = cch_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

FILE: design/cch_back.sv
// ----------------------------------------------------------------------------
// cch_back
// cross-multiplies offsets and ranges, runs the iterative cordic and drives
// the result register
// ----------------------------------------------------------------------------
`default_nettype none

module cch_back #(
  parameter int unsigned SAMPLE_BITS  = cch_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = cch_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  input  wire logic [cch_pkg::STATUS_BITS+2*(SAMPLE_BITS+2)+2*(SAMPLE_BITS+1)-1:0] job_i,
  output logic      job_pop_o,
  cch_out_if.source out_o
);
  localparam int unsigned DW = SAMPLE_BITS + 2;
  localparam int unsigned RW = SAMPLE_BITS + 1;
  localparam int unsigned PW = DW + RW + 1;
  localparam int unsigned CW = PW + 2;
  localparam int unsigned AW = cch_pkg::ACC_BITS;
  localparam int unsigned SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int unsigned HW = AW - cch_pkg::ROUND_SHIFT;
  localparam int unsigned JW = cch_pkg::STATUS_BITS + 2*DW + 2*RW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_PRE   = 3'd2;
  localparam logic [2:0] S_ITER  = 3'd3;
  localparam logic [2:0] S_WRAP  = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [SW-1:0]        step_q, step_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_load, out_free;
  cch_pkg::cch_status_e out_status_q, out_status_d;
  logic [cch_pkg::HEADING_BITS-1:0] out_head_q, out_head_d;

  cch_pkg::cch_status_e job_status;
  logic signed [DW-1:0] job_dx, job_dz;
  logic [RW-1:0]        job_rx, job_rz;

  logic signed [DW-1:0] dx_q, dz_q;
  logic [RW-1:0]        rx_q, rz_q;
  logic signed [PW-1:0] px, py;
  logic signed [CW-1:0] x_q, y_q, x_d, y_d, sx_sh, sy_sh;
  logic signed [AW-1:0] acc_q, acc_d, atan_ext, acc_rnd;
  logic [HW-1:0]        rnd;
  logic [cch_pkg::HEADING_BITS-1:0] hd_q, hd_d;
  logic                 load_ops;

  assign job_status = cch_pkg::cch_status_e'(job_i[JW-1 -: cch_pkg::STATUS_BITS]);
  assign job_dx     = job_i[2*DW+2*RW-1 -: DW];
  assign job_dz     = job_i[DW+2*RW-1 -: DW];
  assign job_rx     = job_i[2*RW-1 -: RW];
  assign job_rz     = job_i[RW-1:0];

  assign out_free = !out_valid_q || out_o.ready;

  // cross products, registered into the cordic vector
  assign px = dx_q * $signed({1'b0, rz_q});
  assign py = dz_q * $signed({1'b0, rx_q});

  // one cordic micro-rotation
  assign sx_sh    = x_q >>> step_q;
  assign sy_sh    = y_q >>> step_q;
  assign atan_ext = AW'(cch_pkg::cch_atan(cch_pkg::ATAN_IDX_BITS'(step_q)));

  assign acc_rnd = acc_q + cch_pkg::ROUND_HALF;
  assign rnd     = acc_rnd[AW-1:cch_pkg::ROUND_SHIFT];

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    x_d          = x_q;
    y_d          = y_q;
    acc_d        = acc_q;
    hd_d         = hd_q;
    job_pop_o    = 1'b0;
    load_ops     = 1'b0;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_head_d   = out_head_q;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          if (job_status != cch_pkg::ST_HEAD_OK) begin
            if (out_free) begin
              job_pop_o    = 1'b1;
              out_load     = 1'b1;
              out_status_d = job_status;
              out_head_d   = '0;
            end
          end else begin
            job_pop_o = 1'b1;
            load_ops  = 1'b1;
            state_d   = S_MUL;
          end
        end
      end
      S_MUL: begin
        x_d     = CW'(px);
        y_d     = -CW'(py);
        state_d = S_PRE;
      end
      S_PRE: begin
        step_d = '0;
        if (x_q == '0 && y_q == '0) begin
          hd_d    = '0;
          state_d = S_DONE;
        end else begin
          if (x_q < 0) begin
            x_d   = -x_q;
            y_d   = -y_q;
            acc_d = cch_pkg::DEG180_UNITS;
          end else begin
            acc_d = '0;
          end
          state_d = S_ITER;
        end
      end
      S_ITER: begin
        if (y_q > 0) begin
          x_d   = x_q + sy_sh;
          y_d   = y_q - sx_sh;
          acc_d = acc_q + atan_ext;
        end else begin
          x_d   = x_q - sy_sh;
          y_d   = y_q + sx_sh;
          acc_d = acc_q - atan_ext;
        end
        if (step_q == SW'(CORDIC_STEPS - 1)) state_d = S_WRAP;
        else                                  step_d  = step_q + 1'b1;
      end
      S_WRAP: begin
        if (acc_q < 0) acc_d = acc_q + cch_pkg::DEG360_UNITS;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        if (rnd >= cch_pkg::FULL_CIRCLE_64THS)
          hd_d = cch_pkg::HEADING_BITS'(rnd - cch_pkg::FULL_CIRCLE_64THS);
        else
          hd_d = cch_pkg::HEADING_BITS'(rnd);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = cch_pkg::ST_HEAD_OK;
          out_head_d   = hd_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_load)          out_valid_d = 1'b1;
    else if (out_o.ready)  out_valid_d = 1'b0;
    else                   out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ops) begin
      dx_q <= job_dx;
      dz_q <= job_dz;
      rx_q <= job_rx;
      rz_q <= job_rz;
    end
    x_q          <= x_d;
    y_q          <= y_d;
    acc_q        <= acc_d;
    hd_q         <= hd_d;
    out_status_q <= out_status_d;
    out_head_q   <= out_head_d;
  end

  assign out_o.valid                = out_valid_q;
  assign out_o.status               = out_status_q;
  assign out_o.heading_sixtyfourths = out_head_q;

endmodule

`default_nettype wire

FILE: design/compass_calibrate_and_heading_top.sv
// ----------------------------------------------------------------------------
// compass_calibrate_and_heading_top
// magnetometer hard-iron calibration and atan2 heading in 1/64 degree
// ----------------------------------------------------------------------------
// calibration and zero-range requests pass through the job queue and the output
//   register; a heading request also runs the multiply, cordic, wrap and round states
// throughput: one calibration request per cycle while the back end is idle and
//   results are taken; the single shared cordic iteration unit takes one heading at a time
// the front keeps accepting into a QUEUE_DEPTH job queue while the cordic runs
// reset: asynchronous, clears min/max to zero, empties the queue, no output
`default_nettype none

module compass_calibrate_and_heading_top #(
  parameter int unsigned SAMPLE_BITS  = cch_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = cch_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cch_in_if.sink    in_i,
  cch_out_if.source out_o
);
  // job word: status code, centered x and z offsets (doubled), x and z ranges
  localparam int unsigned JW =
    cch_pkg::STATUS_BITS + 2*(SAMPLE_BITS + 2) + 2*(SAMPLE_BITS + 1);

  logic          push, full, job_valid, job_pop;
  logic [JW-1:0] job_in, job_out;

  // front: min/max tracking, classification, one request a cycle if queue has room
  cch_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  // decouples the front from the multi-cycle back end
  cch_queue #(
    .WIDTH (JW),
    .DEPTH (cch_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  // back: cross-multiply, cordic vectoring, rounding and output register
  cch_back #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

FILE: design/cch_checker.sv
// ----------------------------------------------------------------------------
// cch_checker
// port-level checks on the compass block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module cch_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_ready_i,
  input wire logic                               out_valid_i,
  input wire logic                               out_ready_i,
  input wire logic [cch_pkg::STATUS_BITS-1:0]    status_i,
  input wire logic [cch_pkg::HEADING_BITS-1:0]   heading_i
);
  logic [7:0] pending_q;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_fire && !out_fire) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_fire && !in_fire) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(heading_i))
    else $error("stalled result changed");

  // no result without an accepted request behind it
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != '0)
    else $error("result without pending request");

  // only a valid heading carries a nonzero angle
  a_head_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != cch_pkg::ST_HEAD_OK |-> heading_i == '0)
    else $error("nonzero heading on non-heading result");

  // heading stays below a full circle and the reserved status never shows
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> heading_i < 15'd23040 && status_i != cch_pkg::ST_RESERVED)
    else $error("heading or status out of range");

endmodule

bind compass_calibrate_and_heading_top cch_checker u_cch_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .heading_i   (out_o.heading_sixtyfourths)
);

`default_nettype wire

FILE: verif/cch_checker.sv
// ----------------------------------------------------------------------------
// cch_checker
// watches the request and result channels, predicts each result from its own
// copy of the min/max state and compares results in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cch_checker #(
  parameter int unsigned SAMPLE_BITS  = cch_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = cch_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cch_in_if         req_i,
  cch_out_if        res_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ATAN_STEPS = 24;

  // atan(2^-i) in 1/65536 degree
  localparam longint ATAN_UNITS [0:ATAN_STEPS-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    cch_pkg::cch_status_e                  status;
    logic [cch_pkg::HEADING_BITS-1:0]      heading;
  } heading_result_t;

  heading_result_t expected_q[$];

  logic signed [SAMPLE_BITS-1:0] x_low, x_high, z_low, z_high;
  int fails;

  // cordic vectoring of (vx, vy), angle rounded to 1/64 degree
  function automatic logic [cch_pkg::HEADING_BITS-1:0] cordic_heading(
    input longint vx_in,
    input longint vy_in
  );
    longint vx, vy, nx, ny, acc, h;
    vx  = vx_in;
    vy  = vy_in;
    acc = 0;
    if (vx == 0 && vy == 0) return '0;
    if (vx < 0) begin
      vx  = -vx;
      vy  = -vy;
      acc = longint'(cch_pkg::DEG180_UNITS);
    end
    for (int unsigned i = 0; i < CORDIC_STEPS && i < ATAN_STEPS; i++) begin
      if (vy > 0) begin
        nx  = vx + (vy >>> i);
        ny  = vy - (vx >>> i);
        acc = acc + ATAN_UNITS[i];
      end else begin
        nx  = vx - (vy >>> i);
        ny  = vy + (vx >>> i);
        acc = acc - ATAN_UNITS[i];
      end
      vx = nx;
      vy = ny;
    end
    if (acc < 0) acc = acc + longint'(cch_pkg::DEG360_UNITS);
    if (acc < 0) acc = 0;
    h = (acc + 512) >>> 10;
    while (h >= longint'(cch_pkg::FULL_CIRCLE_64THS))
      h = h - longint'(cch_pkg::FULL_CIRCLE_64THS);
    return h[cch_pkg::HEADING_BITS-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heading_result_t want;
    logic signed [SAMPLE_BITS-1:0] sx, sz;
    longint range_x, range_z, dx, dz;
    if (!rst_ni) begin
      x_low  = '0;
      x_high = '0;
      z_low  = '0;
      z_high = '0;
      expected_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // results first, so a request taken at this edge cannot cover a stray result
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result: expected none, actual status %0d heading %0d",
                   $time, res_i.status, res_i.heading_sixtyfourths);
        end else begin
          want = expected_q.pop_front();
          if (res_i.status !== want.status) begin
            fails++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, res_i.status);
          end
          if (res_i.heading_sixtyfourths !== want.heading) begin
            fails++;
            $display("%0t: heading mismatch: expected %0d, actual %0d",
                     $time, want.heading, res_i.heading_sixtyfourths);
          end
        end
      end

      if (req_i.valid && req_i.ready) begin
        sx = req_i.mag_x[SAMPLE_BITS-1:0];
        sz = req_i.mag_z[SAMPLE_BITS-1:0];
        want.status  = cch_pkg::ST_CAL_OK;
        want.heading = '0;
        case (req_i.operation)
          cch_pkg::OP_START_CAL: begin
            x_low  = sx;
            x_high = sx;
            z_low  = sz;
            z_high = sz;
          end
          cch_pkg::OP_CAL_SAMPLE: begin
            if (sx > x_high) x_high = sx;
            if (sx < x_low)  x_low  = sx;
            if (sz > z_high) z_high = sz;
            if (sz < z_low)  z_low  = sz;
          end
          cch_pkg::OP_HEADING: begin
            range_x = longint'(x_high) - longint'(x_low);
            range_z = longint'(z_high) - longint'(z_low);
            if (range_x == 0 || range_z == 0) begin
              want.status = cch_pkg::ST_ZERO_RANGE;
            end else begin
              dx = 2 * longint'(sx) - (longint'(x_low) + longint'(x_high));
              dz = 2 * longint'(sz) - (longint'(z_low) + longint'(z_high));
              want.status  = cch_pkg::ST_HEAD_OK;
              want.heading = cordic_heading(dx * range_z, -dz * range_x);
            end
          end
          default: begin
            // unused code leaves the state alone
          end
        endcase
        expected_q.push_back(want);
      end

      fail_count_o <= fails;
      pending_o    <= expected_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb_compass_calibrate_and_heading_top.sv
// ----------------------------------------------------------------------------
// tb_compass_calibrate_and_heading_top
// drives calibration and heading requests into the compass block, stalls both
// channels at random and lets the checker predict and compare every result
// ----------------------------------------------------------------------------
`default_nettype none

module tb_compass_calibrate_and_heading_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_BITS  = cch_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned CORDIC_STEPS = cch_pkg::CORDIC_STEPS_DEF;

  // random requests per phase, three phases in all
  localparam int PHASE_ITEMS  = 500;
  // hang watchdog limit, far beyond the slowest correct run
  localparam int CYCLE_LIMIT  = 2_000_000;
  // extra wait at the end to catch stray results
  localparam int DRAIN_CYCLES = 4 * (CORDIC_STEPS + 7);

  logic clk_i;
  logic rst_ni;

  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int cycle_count;
  int fail_count;
  int pending_count;

  cch_in_if  req_ch ();
  cch_out_if res_ch ();

  compass_calibrate_and_heading_top #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  tb_cch_checker #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .res_i        (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: ready held low in reset, then drops at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hard stop in case the block hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // random sample: full range when spread is zero, else near the centre
  function automatic logic signed [cch_pkg::FIELD_BITS-1:0] pick_sample(input int centre,
                                                                        input int spread);
    int v;
    if (spread == 0) begin
      v = $urandom;
    end else begin
      v = centre + $urandom_range(2 * spread) - spread;
    end
    return v[cch_pkg::FIELD_BITS-1:0];
  endfunction

  // put one request on the channel and hold it until it is taken
  task automatic send_request(input cch_pkg::cch_op_e op,
                              input logic signed [cch_pkg::FIELD_BITS-1:0] x,
                              input logic signed [cch_pkg::FIELD_BITS-1:0] z);
    logic taken;
    // random sender gaps; valid stays high when no gap is drawn
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.mag_x     <= x;
    req_ch.mag_z     <= z;
    taken = 1'b0;
    // ready is stable by the falling edge, sample it there
    while (!taken) begin
      @(negedge clk_i);
      taken = req_ch.ready;
      @(posedge clk_i);
    end
    items_sent++;
  endtask

  // mostly well-formed sessions: start, widen a few times, then ask headings;
  // the rest is noise with any operation code
  task automatic run_random(input int count);
    int stop_at;
    int cx, cz, spread, n_cal, n_head;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 85) begin
        case ($urandom_range(3))
          0:       spread = 0;
          1:       spread = 3;
          2:       spread = 200;
          default: spread = 5000;
        endcase
        cx = int'($urandom_range(65535)) - 32768;
        cz = int'($urandom_range(65535)) - 32768;
        send_request(cch_pkg::OP_START_CAL, pick_sample(cx, spread),
                     pick_sample(cz, spread));
        n_cal = $urandom_range(8);
        repeat (n_cal)
          send_request(cch_pkg::OP_CAL_SAMPLE, pick_sample(cx, spread),
                       pick_sample(cz, spread));
        n_head = $urandom_range(6, 1);
        repeat (n_head)
          send_request(cch_pkg::OP_HEADING, pick_sample(cx, 2 * spread),
                       pick_sample(cz, 2 * spread));
      end else begin
        send_request(cch_pkg::cch_op_e'($urandom_range(3)), pick_sample(0, 0),
                     pick_sample(0, 0));
      end
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= cch_pkg::OP_START_CAL;
    req_ch.mag_x     <= '0;
    req_ch.mag_z     <= '0;
    send_idle_pct  = 14;
    recv_stall_pct = 71;
    items_sent     = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // heading straight after reset, ranges still zero
    send_request(cch_pkg::OP_HEADING, 16'sd0, 16'sd0);
    // unused code before any calibration
    send_request(cch_pkg::OP_UNUSED, -16'sd1, -16'sd1);
    // widest possible ranges on both axes
    send_request(cch_pkg::OP_START_CAL, 16'sd32767, -16'sd32768);
    send_request(cch_pkg::OP_CAL_SAMPLE, -16'sd32768, 16'sd32767);
    send_request(cch_pkg::OP_HEADING, 16'sd32767, 16'sd32767);
    send_request(cch_pkg::OP_HEADING, -16'sd32768, -16'sd32768);
    send_request(cch_pkg::OP_HEADING, 16'sd0, -16'sd1);
    // symmetric ranges so the midpoint is exactly zero
    send_request(cch_pkg::OP_START_CAL, 16'sd100, -16'sd200);
    send_request(cch_pkg::OP_CAL_SAMPLE, -16'sd100, 16'sd200);
    // sample at the centre
    send_request(cch_pkg::OP_HEADING, 16'sd0, 16'sd0);
    // the four axis directions
    send_request(cch_pkg::OP_HEADING, 16'sd50, 16'sd0);
    send_request(cch_pkg::OP_HEADING, 16'sd0, 16'sd50);
    send_request(cch_pkg::OP_HEADING, -16'sd50, 16'sd0);
    send_request(cch_pkg::OP_HEADING, 16'sd0, -16'sd50);
    // negative x gets the half turn first
    send_request(cch_pkg::OP_HEADING, -16'sd50, 16'sd10);
    // unused code must not disturb the ranges
    send_request(cch_pkg::OP_UNUSED, 16'sd1234, -16'sd1234);
    send_request(cch_pkg::OP_HEADING, -16'sd50, -16'sd10);
    // zero x range only
    send_request(cch_pkg::OP_START_CAL, 16'sd5, 16'sd5);
    send_request(cch_pkg::OP_CAL_SAMPLE, 16'sd5, 16'sd9);
    send_request(cch_pkg::OP_HEADING, 16'sd7, 16'sd6);
    // zero z range only
    send_request(cch_pkg::OP_START_CAL, 16'sd1, 16'sd7);
    send_request(cch_pkg::OP_CAL_SAMPLE, 16'sd3, 16'sd7);
    send_request(cch_pkg::OP_HEADING, 16'sd2, 16'sd8);
    // start with no widening leaves both ranges zero
    send_request(cch_pkg::OP_START_CAL, 16'sd0, 16'sd0);
    send_request(cch_pkg::OP_HEADING, 16'sd1, 16'sd1);

    // slow receiver
    run_random(PHASE_ITEMS);
    // slow sender
    send_idle_pct  = 71;
    recv_stall_pct = 14;
    run_random(PHASE_ITEMS);
    // back to back
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(PHASE_ITEMS);

    req_ch.valid <= 1'b0;

    // wait for every predicted result, then catch any stray ones
    do @(negedge clk_i); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
